[sv/grbr_pkg.sv]
package grbr_pkg;

	// scan unit and row padding codes
	localparam logic [1:0] CODE_BYTE     = 2'd0;
	localparam logic [1:0] CODE_HALFWORD = 2'd1;
	localparam logic [1:0] CODE_WORD     = 2'd2;
	localparam logic [1:0] CODE_INVALID  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_UNIT_CODE      = 2'd0;
	localparam logic [1:0] REG_PAD_CODE       = 2'd1;
	localparam logic [1:0] REG_BYTE_ORDER_MSB = 2'd2;
	localparam logic [1:0] REG_BIT_ORDER_MSB  = 2'd3;

	localparam int unsigned CFG_DATA_W = 2;

	typedef struct packed {
		logic [1:0] unit_code;
		logic [1:0] pad_code;
		logic       byte_order_msb;
		logic       bit_order_msb;
	} grbr_cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       glyph_start;
		logic [7:0] width_minus_one;
		logic [7:0] height_minus_one;
		logic [1:0] start_phase;
	} grbr_item_t;

	typedef struct packed {
		logic [31:0] pixel_bits;
		logic [5:0]  bit_count;
		logic        row_end;
		logic        glyph_end;
		logic        format_error;
	} grbr_result_t;

	typedef struct packed {
		logic [31:0] unit_word;
		logic [1:0]  unit_byte_count;
		logic [8:0]  row_pixels_done;
		logic [7:0]  rows_done;
		logic [1:0]  align_phase;
		logic        in_padding;
		logic [7:0]  glyph_width_reg;
		logic [7:0]  glyph_height_reg;
		logic        dropping_glyph;
	} grbr_state_t;

	// mirror all 32 bits of a word
	function automatic logic [31:0] rev32(input logic [31:0] v);
		logic [31:0] r;
		for (int k = 0; k < 32; k++) begin
			r[31-k] = v[k];
		end
		return r;
	endfunction

endpackage

[sv/grbr_ifs.sv]
interface grbr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       glyph_start;
	logic [7:0] width_minus_one;
	logic [7:0] height_minus_one;
	logic [1:0] start_phase;

	modport source (
		output valid, data_byte, glyph_start, width_minus_one, height_minus_one,
			start_phase,
		input  ready
	);
	modport sink (
		input  valid, data_byte, glyph_start, width_minus_one, height_minus_one,
			start_phase,
		output ready
	);
endinterface

interface grbr_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_bits;
	logic [5:0]  bit_count;
	logic        row_end;
	logic        glyph_end;
	logic        format_error;

	modport source (
		output valid, pixel_bits, bit_count, row_end, glyph_end, format_error,
		input  ready
	);
	modport sink (
		input  valid, pixel_bits, bit_count, row_end, glyph_end, format_error,
		output ready
	);
endinterface

[sv/grbr_cfg_regs.sv]
module grbr_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [grbr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output grbr_pkg::grbr_cfg_t        cfg
);
	import grbr_pkg::*;

	grbr_cfg_t cfg_q;

	// register write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_UNIT_CODE:      cfg_q.unit_code      <= cfg_wdata[1:0];
				REG_PAD_CODE:       cfg_q.pad_code       <= cfg_wdata[1:0];
				REG_BYTE_ORDER_MSB: cfg_q.byte_order_msb <= cfg_wdata[0];
				REG_BIT_ORDER_MSB:  cfg_q.bit_order_msb  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

[sv/grbr_step.sv]
module grbr_step #(
	parameter int unsigned MAX_GLYPH_DIM = 256
) (
	input  grbr_pkg::grbr_cfg_t    cfg,
	input  grbr_pkg::grbr_state_t  st,
	input  grbr_pkg::grbr_item_t   item,
	output grbr_pkg::grbr_state_t  st_next,
	output logic                   has_result,
	output grbr_pkg::grbr_result_t result
);
	import grbr_pkg::*;

	// dimensions never exceed 256 with 8-bit fields
	localparam logic [8:0] DIM_CAP = (MAX_GLYPH_DIM > 256) ? 9'd256 : 9'(MAX_GLYPH_DIM);

	logic        bad;
	logic [1:0]  pad_mask;
	logic [2:0]  nbytes;
	logic [5:0]  ubits;
	logic [31:0] word_acc;
	logic [31:0] word_m;
	logic [31:0] swapped;
	logic [31:0] oriented;
	logic [32:0] cnt_mask;
	logic [8:0]  wpx;
	logic [8:0]  hpx;
	logic [8:0]  remain;
	logic [8:0]  rpd_sum;
	logic [5:0]  cnt;
	grbr_state_t s;

	assign bad = (cfg.unit_code == CODE_INVALID) || (cfg.pad_code == CODE_INVALID) ||
		(cfg.unit_code > cfg.pad_code);

	// unit geometry from the current codes
	always_comb begin
		case (cfg.unit_code)
			CODE_BYTE:     begin nbytes = 3'd1; ubits = 6'd8;  end
			CODE_HALFWORD: begin nbytes = 3'd2; ubits = 6'd16; end
			default:       begin nbytes = 3'd4; ubits = 6'd32; end
		endcase
		case (cfg.pad_code)
			CODE_BYTE:     pad_mask = 2'd0;
			CODE_HALFWORD: pad_mask = 2'd1;
			default:       pad_mask = 2'd3;
		endcase
	end

	// glyph limits
	always_comb begin
		logic [8:0] w1;
		logic [8:0] h1;
		w1  = {1'b0, s.glyph_width_reg} + 9'd1;
		h1  = {1'b0, s.glyph_height_reg} + 9'd1;
		wpx = (w1 > DIM_CAP) ? DIM_CAP : w1;
		hpx = (h1 > DIM_CAP) ? DIM_CAP : h1;
	end

	// state after a glyph start is applied
	always_comb begin
		s = st;
		if (item.glyph_start) begin
			s.glyph_width_reg  = item.width_minus_one;
			s.glyph_height_reg = item.height_minus_one;
			s.align_phase      = item.start_phase;
			s.unit_word        = '0;
			s.unit_byte_count  = '0;
			s.row_pixels_done  = '0;
			s.rows_done        = '0;
			s.in_padding       = 1'b0;
			s.dropping_glyph   = 1'b0;
		end
	end

	// gather, swap and orient the completed unit
	always_comb begin
		word_acc = s.unit_word | (32'(item.data_byte) << {s.unit_byte_count, 3'b000});
		case (cfg.unit_code)
			CODE_BYTE:     word_m = {24'd0, word_acc[7:0]};
			CODE_HALFWORD: word_m = {16'd0, word_acc[15:0]};
			default:       word_m = word_acc;
		endcase
		swapped = word_m;
		if (cfg.byte_order_msb) begin
			case (cfg.unit_code)
				CODE_HALFWORD: swapped = {16'd0, word_m[7:0], word_m[15:8]};
				CODE_WORD:     swapped = {word_m[7:0], word_m[15:8], word_m[23:16],
					word_m[31:24]};
				default:       swapped = word_m;
			endcase
		end
		oriented = cfg.bit_order_msb ? swapped : (rev32(swapped) >> (6'd32 - ubits));
		remain   = (s.row_pixels_done < wpx) ? (wpx - s.row_pixels_done) : 9'd0;
		cnt      = (remain < {3'd0, ubits}) ? remain[5:0] : ubits;
		cnt_mask = (33'd1 << cnt) - 33'd1;
		rpd_sum  = s.row_pixels_done + {3'd0, ubits};
	end

	// next state and result
	always_comb begin
		st_next    = st;
		has_result = 1'b0;
		result     = '0;
		if (item.glyph_start && bad) begin
			st_next                = s;
			st_next.dropping_glyph = 1'b1;
			has_result             = 1'b1;
			result.format_error    = 1'b1;
		end else if (!item.glyph_start && (st.dropping_glyph || bad)) begin
			st_next = st;
		end else if (s.in_padding) begin
			st_next             = s;
			st_next.align_phase = s.align_phase + 2'd1;
			if (((s.align_phase + 2'd1) & pad_mask) == 2'd0) begin
				st_next.in_padding = 1'b0;
			end
		end else if ({1'b0, s.unit_byte_count} + 3'd1 < nbytes) begin
			st_next                 = s;
			st_next.unit_word       = word_acc;
			st_next.align_phase     = s.align_phase + 2'd1;
			st_next.unit_byte_count = s.unit_byte_count + 2'd1;
		end else begin
			st_next                 = s;
			st_next.unit_word       = '0;
			st_next.unit_byte_count = '0;
			st_next.align_phase     = s.align_phase + 2'd1;
			st_next.row_pixels_done = rpd_sum;
			has_result              = 1'b1;
			result.pixel_bits       = oriented & cnt_mask[31:0];
			result.bit_count        = cnt;
			if (rpd_sum >= wpx) begin
				result.row_end          = 1'b1;
				st_next.row_pixels_done = '0;
				if ({1'b0, s.rows_done} + 9'd1 >= hpx) begin
					result.glyph_end       = 1'b1;
					st_next.dropping_glyph = 1'b1;
				end else begin
					st_next.rows_done = s.rows_done + 8'd1;
					if (((s.align_phase + 2'd1) & pad_mask) != 2'd0) begin
						st_next.in_padding = 1'b1;
					end
				end
			end
		end
	end
endmodule

[sv/glyph_bitmap_row_repacker_unit.sv]
// Glyph bitmap row repacker: takes one raw bitmap byte per transfer and gives
// one result per completed scan unit (1, 2 or 4 bytes) holding that unit's
// pixels of the current row, or one format_error result at a glyph start
// under an impossible unit/pad setting. Bytes that fill a unit, row padding
// and bytes after a glyph ends give no result. A byte is taken every cycle
// while results drain: each byte is held in an input register, the unit and
// row counters are updated by combinational logic into a state register,
// and a result register drives the output. Configuration must be written
// through cfg_we/cfg_index/cfg_wdata while no bytes are in flight, which
// the block does not enforce; it takes effect on the next byte.
module glyph_bitmap_row_repacker_unit #(
	parameter int unsigned MAX_GLYPH_DIM = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [grbr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	grbr_in_if.sink                         in_chan,
	grbr_out_if.source                      out_chan
);
	import grbr_pkg::*;

	grbr_cfg_t    cfg;
	grbr_item_t   item_s1;
	logic         valid_s1;
	grbr_state_t  state_q;
	grbr_state_t  state_next;
	logic         has_result;
	grbr_result_t result;
	grbr_result_t result_q;
	logic         out_valid_q;
	logic         out_free;
	logic         fire_s1;

	grbr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	grbr_step #(
		.MAX_GLYPH_DIM (MAX_GLYPH_DIM)
	) u_step (
		.cfg        (cfg),
		.st         (state_q),
		.item       (item_s1),
		.st_next    (state_next),
		.has_result (has_result),
		.result     (result)
	);

	// handshake
	assign out_free      = !out_valid_q || out_chan.ready;
	assign fire_s1       = valid_s1 && out_free;
	assign in_chan.ready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_chan.ready) begin
			valid_s1 <= in_chan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_chan.ready && in_chan.valid) begin
			item_s1.data_byte        <= in_chan.data_byte;
			item_s1.glyph_start      <= in_chan.glyph_start;
			item_s1.width_minus_one  <= in_chan.width_minus_one;
			item_s1.height_minus_one <= in_chan.height_minus_one;
			item_s1.start_phase      <= in_chan.start_phase;
		end
	end

	// glyph state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire_s1) begin
			state_q <= state_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && has_result) begin
			result_q <= result;
		end
	end

	assign out_chan.valid        = out_valid_q;
	assign out_chan.pixel_bits   = result_q.pixel_bits;
	assign out_chan.bit_count    = result_q.bit_count;
	assign out_chan.row_end      = result_q.row_end;
	assign out_chan.glyph_end    = result_q.glyph_end;
	assign out_chan.format_error = result_q.format_error;
endmodule

[sv/grbr_checker.sv]
module grbr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] pixel_bits,
	input logic [5:0]  bit_count,
	input logic        row_end,
	input logic        glyph_end,
	input logic        format_error
);
	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_bits) &&
			$stable(bit_count) && $stable(row_end) && $stable(glyph_end) &&
			$stable(format_error))
		else $error("output changed while stalled");

	// error result carries nothing else
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && format_error |-> pixel_bits == 32'd0 && bit_count == 6'd0 &&
			!row_end && !glyph_end)
		else $error("error result with payload");

	// glyph end closes a row
	a_glyph_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && glyph_end |-> row_end)
		else $error("glyph end without row end");

	// count in range and no bits above it
	a_bits_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bit_count <= 6'd32 && (33'(pixel_bits) >> bit_count) == 33'd0)
		else $error("pixel bits beyond bit count");
endmodule

bind glyph_bitmap_row_repacker_unit grbr_checker u_grbr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_chan.valid),
	.out_ready    (out_chan.ready),
	.pixel_bits   (out_chan.pixel_bits),
	.bit_count    (out_chan.bit_count),
	.row_end      (out_chan.row_end),
	.glyph_end    (out_chan.glyph_end),
	.format_error (out_chan.format_error)
);

[bench/glyph_bitmap_row_repacker_unit_tb.sv]
`timescale 1ns / 1ps

module glyph_bitmap_row_repacker_unit_tb;
	import grbr_pkg::*;

	localparam int unsigned MAX_DIM = 256;
	localparam int unsigned SETTLE = 8;
	localparam int unsigned BODY_ITEMS = 1750;
	localparam int DIR_ROWS = 23;

	// one row of the directed table: optional format, the byte, optional typed result
	typedef struct packed {
		logic         set_fmt;
		grbr_cfg_t    fmt;
		grbr_item_t   item;
		logic         has_lit;
		grbr_result_t lit;
	} dir_row_t;

	typedef struct packed {
		logic         has_lit;
		grbr_result_t run;
	} typed_run_t;

	typedef enum {RX_OPEN, RX_COIN, RX_CHOKE, RX_MASK} rx_mode_t;

	localparam grbr_cfg_t    NO_FMT  = '0;
	localparam grbr_result_t NO_RUN  = '0;
	localparam grbr_result_t ERR_RUN = {32'd0, 6'd0, 1'b0, 1'b0, 1'b1};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	grbr_in_if  in_chan ();
	grbr_out_if out_chan ();

	glyph_bitmap_row_repacker_unit #(
		.MAX_GLYPH_DIM(MAX_DIM)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_chan  (in_chan),
		.out_chan (out_chan)
	);

	always #5 clk = ~clk;

	// expected pixel runs and typed overrides from the directed table
	grbr_result_t pending_runs[$];
	typed_run_t   typed_runs[$];
	int errors = 0;

	// shadow of the block: format registers and glyph walk state
	grbr_cfg_t   fmt = '0;
	logic [31:0] unit_acc = '0;
	logic [1:0]  unit_fill = '0;
	int unsigned row_px = 0;
	logic [7:0]  rows_seen = '0;
	logic [1:0]  phase_ptr = '0;
	bit          in_pad = 1'b0;
	logic [7:0]  width_m1 = '0;
	logic [7:0]  height_m1 = '0;
	bit          dropping = 1'b0;

	// driver side
	grbr_cfg_t   drv_fmt = '0;
	int unsigned burst_left = 0;
	int unsigned body_sent = 0;

	function automatic bit format_bad(input grbr_cfg_t f);
		return f.unit_code == CODE_INVALID || f.pad_code == CODE_INVALID ||
			f.unit_code > f.pad_code;
	endfunction

	// advance the shadow by one byte; returns 1 when a pixel run comes out
	function automatic bit repack_byte(input grbr_item_t it, output grbr_result_t run);
		int unsigned nbytes, padbytes, ubits, wpx, hpx, remain, cnt;
		logic [31:0] v;
		bit bad;
		run = '0;
		bad = format_bad(fmt);
		if (it.glyph_start) begin
			width_m1 = it.width_minus_one;
			height_m1 = it.height_minus_one;
			phase_ptr = it.start_phase;
			unit_acc = '0;
			unit_fill = '0;
			row_px = 0;
			rows_seen = '0;
			in_pad = 1'b0;
			dropping = 1'b0;
			if (bad) begin
				dropping = 1'b1;
				run.format_error = 1'b1;
				return 1'b1;
			end
		end else if (dropping || bad) begin
			return 1'b0;
		end

		// row padding up to the pad boundary
		padbytes = 1 << fmt.pad_code;
		if (in_pad) begin
			phase_ptr = phase_ptr + 2'd1;
			if ((int'(phase_ptr) & (padbytes - 1)) == 0)
				in_pad = 1'b0;
			return 1'b0;
		end

		// gather the scan unit little-endian
		nbytes = 1 << fmt.unit_code;
		unit_acc |= {24'd0, it.data_byte} << (8 * unit_fill);
		phase_ptr = phase_ptr + 2'd1;
		if (int'(unit_fill) + 1 < nbytes) begin
			unit_fill = unit_fill + 2'd1;
			return 1'b0;
		end

		ubits = 8 * nbytes;
		v = unit_acc & 32'((64'd1 << ubits) - 1);
		unit_acc = '0;
		unit_fill = '0;
		if (fmt.byte_order_msb) begin
			if (nbytes == 2)
				v = {16'd0, v[7:0], v[15:8]};
			else if (nbytes == 4)
				v = {v[7:0], v[15:8], v[23:16], v[31:24]};
		end
		if (!fmt.bit_order_msb) begin
			v = {<<{v}};
			v = v >> (32 - ubits);
		end

		// clip to what is left of the row
		wpx = int'(width_m1) + 1;
		hpx = int'(height_m1) + 1;
		if (wpx > MAX_DIM) wpx = MAX_DIM;
		if (hpx > MAX_DIM) hpx = MAX_DIM;
		remain = row_px < wpx ? wpx - row_px : 0;
		cnt = remain < ubits ? remain : ubits;
		run.pixel_bits = v & 32'((64'd1 << cnt) - 1);
		run.bit_count = 6'(cnt);

		row_px += ubits;
		if (row_px >= wpx) begin
			run.row_end = 1'b1;
			row_px = 0;
			if (int'(rows_seen) + 1 >= hpx) begin
				run.glyph_end = 1'b1;
				dropping = 1'b1;
			end else begin
				rows_seen = rows_seen + 8'd1;
				if ((int'(phase_ptr) & (padbytes - 1)) != 0)
					in_pad = 1'b1;
			end
		end
		return 1'b1;
	endfunction

	// register writes, accepted transfers in, pixel runs out
	always @(posedge clk) begin : monitor
		grbr_item_t   seen;
		grbr_result_t want, got;
		typed_run_t   note;
		bit           has;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_UNIT_CODE:      fmt.unit_code = cfg_wdata[1:0];
					REG_PAD_CODE:       fmt.pad_code = cfg_wdata[1:0];
					REG_BYTE_ORDER_MSB: fmt.byte_order_msb = cfg_wdata[0];
					REG_BIT_ORDER_MSB:  fmt.bit_order_msb = cfg_wdata[0];
					default: ;
				endcase
			end
			if (in_chan.valid && in_chan.ready) begin
				seen = {in_chan.data_byte, in_chan.glyph_start, in_chan.width_minus_one,
					in_chan.height_minus_one, in_chan.start_phase};
				has = repack_byte(seen, want);
				if (typed_runs.size() != 0) begin
					note = typed_runs.pop_front();
					if (note.has_lit) begin
						has = 1'b1;
						want = note.run;
					end
				end
				if (has)
					pending_runs.push_back(want);
			end
			if (out_chan.valid && out_chan.ready) begin
				got = {out_chan.pixel_bits, out_chan.bit_count, out_chan.row_end,
					out_chan.glyph_end, out_chan.format_error};
				if (pending_runs.size() == 0) begin
					$error("result transfer with no expected result waiting");
					errors++;
				end else begin
					want = pending_runs.pop_front();
					if (got.pixel_bits !== want.pixel_bits) begin
						$error("pixel_bits: expected %h, got %h", want.pixel_bits, got.pixel_bits);
						errors++;
					end
					if (got.bit_count !== want.bit_count) begin
						$error("bit_count: expected %0d, got %0d", want.bit_count, got.bit_count);
						errors++;
					end
					if (got.row_end !== want.row_end) begin
						$error("row_end: expected %b, got %b", want.row_end, got.row_end);
						errors++;
					end
					if (got.glyph_end !== want.glyph_end) begin
						$error("glyph_end: expected %b, got %b", want.glyph_end, got.glyph_end);
						errors++;
					end
					if (got.format_error !== want.format_error) begin
						$error("format_error: expected %b, got %b", want.format_error,
							got.format_error);
						errors++;
					end
				end
			end
		end
	end

	// receiver stall pattern, changing mode when a randomly drawn span runs out
	rx_mode_t    rx_mode = RX_OPEN;
	int unsigned rx_left = 0;
	logic [31:0] rx_mask = '1;

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(8, 64);
			rx_mask = $urandom;
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN:  out_chan.ready = 1'b1;
			RX_COIN:  out_chan.ready = 1'($urandom_range(0, 1));
			RX_CHOKE: out_chan.ready = ($urandom_range(0, 3) == 0);
			RX_MASK:  out_chan.ready = rx_mask[rx_left % 32];
			default:  out_chan.ready = 1'b1;
		endcase
	end

	// directed rows: reset behavior, extremes, impossible formats, padding,
	// mid-glyph unit shrink and a format gone impossible mid-glyph
	function automatic dir_row_t dir_row(input int i);
		case (i)
			// byte before any glyph start acts as a 1x1 glyph
			0:  return {1'b0, NO_FMT, 8'h80, 1'b0, 8'd0, 8'd0, 2'd0,
				1'b1, 32'h1, 6'd1, 1'b1, 1'b1, 1'b0};
			1:  return {1'b0, NO_FMT, 8'h55, 1'b0, 8'hff, 8'hff, 2'd3, 1'b0, NO_RUN};
			2:  return {1'b0, NO_FMT, 8'h00, 1'b1, 8'd0, 8'd0, 2'd0,
				1'b1, 32'h0, 6'd1, 1'b1, 1'b1, 1'b0};
			// impossible formats give one error and drop the glyph
			3:  return {1'b1, CODE_INVALID, CODE_BYTE, 1'b0, 1'b0,
				8'h3c, 1'b1, 8'd7, 8'd0, 2'd1, 1'b1, ERR_RUN};
			4:  return {1'b0, NO_FMT, 8'hff, 1'b0, 8'd0, 8'd0, 2'd0, 1'b0, NO_RUN};
			5:  return {1'b1, CODE_HALFWORD, CODE_BYTE, 1'b0, 1'b0,
				8'ha5, 1'b1, 8'd3, 8'd3, 2'd2, 1'b1, ERR_RUN};
			6:  return {1'b1, CODE_BYTE, CODE_INVALID, 1'b1, 1'b1,
				8'h5a, 1'b1, 8'd0, 8'd0, 2'd0, 1'b1, ERR_RUN};
			// widest glyph, word unit, byte swap, no bit reversal
			7:  return {1'b1, CODE_WORD, CODE_WORD, 1'b1, 1'b1,
				8'hff, 1'b1, 8'hff, 8'hff, 2'd3, 1'b0, NO_RUN};
			8:  return {1'b0, NO_FMT, 8'h00, 1'b0, 8'd0, 8'd0, 2'd0, 1'b0, NO_RUN};
			9:  return {1'b0, NO_FMT, 8'h5a, 1'b0, 8'd0, 8'd0, 2'd0, 1'b0, NO_RUN};
			10: return {1'b0, NO_FMT, 8'ha5, 1'b0, 8'd0, 8'd0, 2'd0,
				1'b1, 32'hff005aa5, 6'd32, 1'b0, 1'b0, 1'b0};
			// halfword unit, word padding: one pad byte after row one
			11: return {1'b1, CODE_HALFWORD, CODE_WORD, 1'b0, 1'b0,
				8'hc3, 1'b1, 8'd9, 8'd1, 2'd1, 1'b0, NO_RUN};
			12: return {1'b0, NO_FMT, 8'h81, 1'b0, 8'd0, 8'd0, 2'd0, 1'b0, NO_RUN};
			13: return {1'b0, NO_FMT, 8'h00, 1'b0, 8'd0, 8'd0, 2'd0, 1'b0, NO_RUN};
			14: return {1'b0, NO_FMT, 8'h7e, 1'b0, 8'd0, 8'd0, 2'd0, 1'b0, NO_RUN};
			15: return {1'b0, NO_FMT, 8'he7, 1'b0, 8'd0, 8'd0, 2'd0, 1'b0, NO_RUN};
			// trailing byte after glyph end is ignored
			16: return {1'b0, NO_FMT, 8'h99, 1'b0, 8'd0, 8'd0, 2'd0, 1'b0, NO_RUN};
			// word unit cut to halfword mid-glyph completes from gathered bytes
			17: return {1'b1, CODE_WORD, CODE_WORD, 1'b0, 1'b1,
				8'h11, 1'b1, 8'd63, 8'd1, 2'd0, 1'b0, NO_RUN};
			18: return {1'b0, NO_FMT, 8'h22, 1'b0, 8'd0, 8'd0, 2'd0, 1'b0, NO_RUN};
			19: return {1'b1, CODE_HALFWORD, CODE_WORD, 1'b1, 1'b0,
				8'h33, 1'b0, 8'd0, 8'd0, 2'd0, 1'b0, NO_RUN};
			// format made impossible mid-glyph, then valid again
			20: return {1'b1, CODE_INVALID, CODE_WORD, 1'b0, 1'b0,
				8'h44, 1'b0, 8'd0, 8'd0, 2'd0, 1'b0, NO_RUN};
			21: return {1'b1, CODE_BYTE, CODE_HALFWORD, 1'b0, 1'b0,
				8'h55, 1'b0, 8'd0, 8'd0, 2'd0, 1'b0, NO_RUN};
			22: return {1'b1, CODE_BYTE, CODE_BYTE, 1'b0, 1'b0,
				8'hf0, 1'b1, 8'hfe, 8'd0, 2'd2, 1'b0, NO_RUN};
			default: return '0;
		endcase
	endfunction

	// one byte transfer, with bursts and random gaps in between
	task automatic send_byte(input grbr_item_t it);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
			in_chan.valid = 1'b0;
			{in_chan.data_byte, in_chan.glyph_start, in_chan.width_minus_one,
				in_chan.height_minus_one, in_chan.start_phase} = 27'($urandom);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
				$urandom_range(1, 30);
		end
		burst_left--;
		{in_chan.data_byte, in_chan.glyph_start, in_chan.width_minus_one,
			in_chan.height_minus_one, in_chan.start_phase} = it;
		in_chan.valid = 1'b1;
		@(posedge clk);
		while (!in_chan.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
	endtask

	// wait for the block to go idle, then rewrite all four registers
	task automatic change_format(input grbr_cfg_t f);
		in_chan.valid = 1'b0;
		while (pending_runs.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		write_reg(REG_UNIT_CODE, f.unit_code);
		write_reg(REG_PAD_CODE, f.pad_code);
		write_reg(REG_BYTE_ORDER_MSB, {1'($urandom_range(0, 1)), f.byte_order_msb});
		write_reg(REG_BIT_ORDER_MSB, {1'($urandom_range(0, 1)), f.bit_order_msb});
		cfg_we = 1'b0;
		drv_fmt = f;
	endtask

	// mostly valid formats, now and then any code at all
	function automatic grbr_cfg_t pick_format();
		grbr_cfg_t f;
		if ($urandom_range(0, 7) == 0) begin
			f.unit_code = 2'($urandom);
			f.pad_code = 2'($urandom);
		end else begin
			f.unit_code = 2'($urandom_range(CODE_BYTE, CODE_WORD));
			f.pad_code = 2'($urandom_range(f.unit_code, CODE_WORD));
		end
		f.byte_order_msb = 1'($urandom);
		f.bit_order_msb = 1'($urandom);
		return f;
	endfunction

	// bytes in a well-formed glyph, row padding included, none after the last row
	function automatic int unsigned glyph_len(input grbr_cfg_t f, input int unsigned w,
			input int unsigned h, input int unsigned ph);
		int unsigned nb, pb, per_row, p, total;
		nb = 1 << f.unit_code;
		pb = 1 << f.pad_code;
		per_row = ((w + 8 * nb - 1) / (8 * nb)) * nb;
		p = ph;
		total = 0;
		for (int r = 0; r < h; r++) begin
			total += per_row;
			p = (p + per_row) % 4;
			if (r + 1 < h) begin
				while (p % pb != 0) begin
					p = (p + 1) % 4;
					total++;
				end
			end
		end
		return total;
	endfunction

	// one glyph with random content; some cut short, some with trailing bytes
	task automatic send_glyph();
		grbr_item_t it;
		int unsigned w1, h1, ph, n, extra;
		bit bad;
		w1 = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 39);
		h1 = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
		ph = $urandom_range(0, 3);
		bad = format_bad(drv_fmt);
		n = bad ? $urandom_range(1, 5) : glyph_len(drv_fmt, w1 + 1, h1 + 1, ph);
		if (n > 64)
			n = $urandom_range(8, 64);
		else if (n > 1 && $urandom_range(0, 9) == 0)
			n = $urandom_range(1, n - 1);
		extra = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
		for (int k = 0; k < n + extra; k++) begin
			it.data_byte = 8'($urandom);
			it.glyph_start = (k == 0);
			it.width_minus_one = (k == 0) ? 8'(w1) : 8'($urandom);
			it.height_minus_one = (k == 0) ? 8'(h1) : 8'($urandom);
			it.start_phase = (k == 0) ? 2'(ph) : 2'($urandom);
			if (k > 0 && $urandom_range(0, 79) == 0)
				change_format(pick_format());
			send_byte(it);
			if (!bad && k < n)
				body_sent++;
		end
	endtask

	initial begin
		dir_row_t r;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_UNIT_CODE;
		cfg_wdata = '0;
		in_chan.valid = 1'b0;
		{in_chan.data_byte, in_chan.glyph_start, in_chan.width_minus_one,
			in_chan.height_minus_one, in_chan.start_phase} = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			r = dir_row(i);
			if (r.set_fmt)
				change_format(r.fmt);
			typed_runs.push_back({r.has_lit, r.lit});
			send_byte(r.item);
		end

		// random glyph stream with format changes between and inside glyphs
		while (body_sent < BODY_ITEMS) begin
			if ($urandom_range(0, 5) == 0)
				change_format(pick_format());
			send_glyph();
		end

		// drain
		in_chan.valid = 1'b0;
		while (pending_runs.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (errors == 0 && pending_runs.size() == 0)
			$display("glyph_bitmap_row_repacker_unit_tb: clean");
		else
			$display("glyph_bitmap_row_repacker_unit_tb: errors");
		$finish;
	end

	// watchdog
	initial begin
		#(5_000_000);
		$display("glyph_bitmap_row_repacker_unit_tb: errors");
		$finish;
	end

endmodule
